/* rtl/cgps_pkg.sv */
// Shared types, constants and palette tables for the cost grid pseudocolor sampler.
// No dependencies; used by every module of the block.
package cgps_pkg;

  // Grid limits
  localparam int MAX_GRID_WIDTH  = 4096;
  localparam int MAX_GRID_HEIGHT = 4096;
  localparam int MAX_STRIDE      = 255;
  localparam int COL_W           = $clog2(MAX_GRID_WIDTH);
  localparam int ROW_W           = $clog2(MAX_GRID_HEIGHT);

  // Field widths
  localparam int COST_W   = 8;
  localparam int STRIDE_W = 8;
  localparam int GWIDTH_W = 13;
  localparam int PAL_W    = 3;
  localparam int CTR_W    = 14;
  localparam int CHAN_W   = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int S_TDATA_W  = 8;
  localparam int M_TDATA_W  = 56;

  // Normalized value: unsigned 17-bit fraction of 65536
  localparam int NQ_W = 17;
  localparam int QUO_W = 16;
  localparam logic [NQ_W-1:0] ONE_Q  = NQ_W'(65536);
  localparam logic [NQ_W-1:0] HALF_Q = NQ_W'(32768);

  // Channel blend pipeline depth
  localparam int BLEND_LAT = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COST  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_COST  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SHOW_UNK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_W    = 3'd5;

  // Palette codes
  localparam logic [PAL_W-1:0] PAL_SAFETY = 3'd0;
  localparam logic [PAL_W-1:0] PAL_PASTEL = 3'd1;
  localparam logic [PAL_W-1:0] PAL_CYAN   = 3'd6;

  // Unknown-cell greys
  localparam logic [CHAN_W-1:0] GREY_DARK     = 8'd51;
  localparam logic [CHAN_W-1:0] GREY_PASTEL_RG = 8'd217;
  localparam logic [CHAN_W-1:0] GREY_PASTEL_B  = 8'd224;

  // Palette endpoints in hundredths
  typedef logic [6:0] pct_t;

  // Per two-point palette: low r,g,b then high r,g,b
  localparam pct_t PASTEL_TAB [6][6] = '{
    '{7'd72, 7'd86, 7'd95, 7'd95, 7'd80, 7'd86},
    '{7'd72, 7'd86, 7'd95, 7'd95, 7'd77, 7'd77},
    '{7'd72, 7'd92, 7'd78, 7'd95, 7'd76, 7'd76},
    '{7'd97, 7'd86, 7'd70, 7'd95, 7'd73, 7'd73},
    '{7'd82, 7'd76, 7'd95, 7'd96, 7'd74, 7'd76},
    '{7'd71, 7'd92, 7'd93, 7'd95, 7'd74, 7'd76}
  };

  // Safety gradient: low, mid, high points
  localparam pct_t SAFETY_TAB [3][3] = '{
    '{7'd20, 7'd70, 7'd95},
    '{7'd20, 7'd85, 7'd35},
    '{7'd92, 7'd16, 7'd14}
  };

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic div_start;
    logic load_out;
  } cgps_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic keep;
    logic need_div;
    logic div_done;
    logic out_free;
  } cgps_status_t;

endpackage

/* rtl/cgps_div.sv */
// Restoring divider, one quotient bit per cycle, for the cost normalization.
// Depends on cgps_pkg. Computes ({num, 16'(d/2)}) / d for num < d.
module cgps_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cgps_pkg::COST_W-1:0] num_i,
  input  logic [cgps_pkg::COST_W-1:0] den_i,
  output logic                        done_o,
  output logic [cgps_pkg::QUO_W-1:0]  quo_o
);

  localparam int CNT_W = $clog2(cgps_pkg::QUO_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(cgps_pkg::QUO_W - 1);

  logic                        busy_q, busy_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [cgps_pkg::COST_W-1:0] rem_q, rem_d;
  logic [cgps_pkg::COST_W-1:0] den_q, den_d;
  logic [cgps_pkg::QUO_W-1:0]  quo_q, quo_d;
  logic [cgps_pkg::COST_W:0]   trial;
  logic                        ge;

  // One shift-subtract step
  always_comb begin
    trial = {rem_q, quo_q[cgps_pkg::QUO_W-1]};
    ge    = trial >= {1'b0, den_q};
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = num_i;
      den_d  = den_i;
      // low dividend bits hold the rounding offset d/2
      quo_d  = cgps_pkg::QUO_W'(den_i[cgps_pkg::COST_W-1:1]);
    end else if (busy_q) begin
      rem_d = ge ? cgps_pkg::COST_W'(trial - {1'b0, den_q}) : trial[cgps_pkg::COST_W-1:0];
      quo_d = {quo_q[cgps_pkg::QUO_W-2:0], ge};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = busy_q && (cnt_q == LAST);
  assign quo_o  = quo_q;

endmodule

/* rtl/cgps_blend.sv */
// One color channel: blend between two endpoints and scale to 0..255, rounded.
// Depends on cgps_pkg. Three-stage pipeline: product, scale, divide by 100.
module cgps_blend (
  input  logic                        clk_i,
  input  logic [cgps_pkg::NQ_W-1:0]   t_i,
  input  cgps_pkg::pct_t              lo_i,
  input  cgps_pkg::pct_t              hi_i,
  output logic [cgps_pkg::CHAN_W-1:0] chan_o
);

  localparam int PROD_W = 26;
  localparam int SUM_W  = 23;
  localparam int X_W    = 31;
  localparam int Y_W    = 15;
  localparam int R_W    = 28;
  // 65536 * 100 / 2, the rounding offset
  localparam logic [X_W-1:0] ROUND_OFS = X_W'(3276800);
  // floor(y / 100) = (y * 5243) >> 19 for y below 43699
  localparam logic [12:0] RECIP_100 = 13'd5243;

  logic signed [7:0]        diff;
  logic signed [17:0]       t_s;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  cgps_pkg::pct_t           lo_q;
  logic signed [PROD_W-1:0] sum;
  logic [SUM_W-1:0]         s;
  logic [X_W-1:0]           x;
  logic [Y_W-1:0]           y_d, y_q;
  logic [R_W-1:0]           r;
  logic [cgps_pkg::CHAN_W-1:0] z_d, z_q;

  // Stage A: (hi - lo) * t
  always_comb begin
    diff   = $signed({1'b0, hi_i}) - $signed({1'b0, lo_i});
    t_s    = $signed({1'b0, t_i});
    prod_d = diff * t_s;
  end

  // Stage B: 255 * (lo*65536 + prod) + offset, then drop 16 bits
  always_comb begin
    sum = $signed({3'b000, lo_q, 16'h0000}) + prod_q;
    s   = sum[SUM_W-1:0];
    x   = {s, 8'h00} - {8'h00, s} + ROUND_OFS;
    y_d = x[X_W-1:16];
  end

  // Stage C: divide by 100
  always_comb begin
    r   = R_W'(y_q) * R_W'(RECIP_100);
    z_d = r[26:19];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    lo_q   <= lo_i;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign chan_o = z_q;

endmodule

/* rtl/cgps_datapath.sv */
// Datapath: configuration registers, raster counters, normalization, color lanes
// and the output register. Depends on cgps_pkg, cgps_div and cgps_blend.
module cgps_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [cgps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cgps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input item
  input  logic [cgps_pkg::COST_W-1:0]     cell_cost_i,
  input  logic                            frame_start_i,
  // control
  input  cgps_pkg::cgps_cmd_t             cmd_i,
  output cgps_pkg::cgps_status_t          status_o,
  // result
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [cgps_pkg::CTR_W-1:0]      center_col_half_o,
  output logic [cgps_pkg::CTR_W-1:0]      center_row_half_o,
  output logic [cgps_pkg::CHAN_W-1:0]     red_o,
  output logic [cgps_pkg::CHAN_W-1:0]     green_o,
  output logic [cgps_pkg::CHAN_W-1:0]     blue_o,
  output logic                            is_unknown_o
);

  localparam int CW = cgps_pkg::COL_W;
  localparam int RW = cgps_pkg::ROW_W;
  localparam int SW = cgps_pkg::STRIDE_W;
  localparam int GW = cgps_pkg::GWIDTH_W;
  localparam int VW = cgps_pkg::COST_W;

  // ---- configuration registers ----
  logic signed [VW-1:0]         min_q, max_q;
  logic [cgps_pkg::PAL_W-1:0]   pal_q;
  logic                         show_q;
  logic [SW-1:0]                stride_q;
  logic [GW-1:0]                width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q    <= '0;
      max_q    <= VW'(100);
      pal_q    <= cgps_pkg::PAL_SAFETY;
      show_q   <= 1'b0;
      stride_q <= SW'(1);
      width_q  <= GW'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cgps_pkg::REG_MIN_COST: min_q    <= cfg_data_i[VW-1:0];
        cgps_pkg::REG_MAX_COST: max_q    <= cfg_data_i[VW-1:0];
        cgps_pkg::REG_PALETTE:  pal_q    <= cfg_data_i[cgps_pkg::PAL_W-1:0];
        cgps_pkg::REG_SHOW_UNK: show_q   <= cfg_data_i[0];
        cgps_pkg::REG_STRIDE:   stride_q <= cfg_data_i[SW-1:0];
        cgps_pkg::REG_GRID_W:   width_q  <= cfg_data_i[GW-1:0];
        default: ;
      endcase
    end
  end

  // ---- raster counters ----
  logic [CW-1:0] col_q, col_d, cc0;
  logic [RW-1:0] row_q, row_d, rc0;
  logic [SW-1:0] cph_q, cph_d, rph_q, rph_d;
  logic [SW-1:0] stride_eff, cp0, rp0, cp1, rp1;
  logic [GW-1:0] width_eff;
  logic [CW:0]   col_inc;
  logic [RW:0]   row_inc;
  logic [SW:0]   cp_inc, rp_inc;
  logic          cost_neg, keep;

  always_comb begin
    stride_eff = (stride_q == '0) ? SW'(1) : stride_q;
    if (width_q == '0) begin
      width_eff = GW'(1);
    end else if (width_q > GW'(cgps_pkg::MAX_GRID_WIDTH)) begin
      width_eff = GW'(cgps_pkg::MAX_GRID_WIDTH);
    end else begin
      width_eff = width_q;
    end
    // frame start restarts at column 0, row 0
    cc0 = frame_start_i ? '0 : col_q;
    rc0 = frame_start_i ? '0 : row_q;
    cp0 = frame_start_i ? '0 : cph_q;
    rp0 = frame_start_i ? '0 : rph_q;
    // phases left over from a larger stride
    cp1 = (cp0 >= stride_eff) ? '0 : cp0;
    rp1 = (rp0 >= stride_eff) ? '0 : rp0;
    cost_neg = cell_cost_i[VW-1];
    keep = (cp1 == '0) && (rp1 == '0) && (!cost_neg || show_q);

    col_inc = {1'b0, cc0} + (CW+1)'(1);
    row_inc = {1'b0, rc0} + (RW+1)'(1);
    cp_inc  = {1'b0, cp1} + (SW+1)'(1);
    rp_inc  = {1'b0, rp1} + (SW+1)'(1);
    col_d = col_q;
    row_d = row_q;
    cph_d = cph_q;
    rph_d = rph_q;
    if (cmd_i.accept) begin
      if (GW'(col_inc) >= width_eff) begin
        // row end
        col_d = '0;
        cph_d = '0;
        if (row_inc >= (RW+1)'(cgps_pkg::MAX_GRID_HEIGHT)) begin
          row_d = '0;
          rph_d = '0;
        end else begin
          row_d = row_inc[RW-1:0];
          rph_d = (rp_inc >= {1'b0, stride_eff}) ? '0 : rp_inc[SW-1:0];
        end
      end else begin
        col_d = col_inc[CW-1:0];
        row_d = rc0;
        cph_d = (cp_inc >= {1'b0, stride_eff}) ? '0 : cp_inc[SW-1:0];
        rph_d = rp1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      cph_q <= '0;
      rph_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      cph_q <= cph_d;
      rph_q <= rph_d;
    end
  end

  // ---- normalization operands ----
  logic signed [VW:0] num_s, den_s;
  logic [VW-1:0]      den_eff;
  logic               n_zero, n_full;

  always_comb begin
    num_s   = $signed({cell_cost_i[VW-1], cell_cost_i}) - $signed({min_q[VW-1], min_q});
    den_s   = $signed({max_q[VW-1], max_q}) - $signed({min_q[VW-1], min_q});
    // empty range divides by one
    den_eff = (den_s < $signed((VW+1)'(1))) ? VW'(1) : den_s[VW-1:0];
    n_zero  = num_s <= $signed((VW+1)'(0));
    n_full  = num_s >= $signed({1'b0, den_eff});
  end

  // captured at accept
  logic [cgps_pkg::CTR_W-1:0] col_half_q, row_half_q;
  logic                       unk_q, zero_q, full_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      col_half_q <= cgps_pkg::CTR_W'({cc0, 1'b0}) + cgps_pkg::CTR_W'(stride_eff);
      row_half_q <= cgps_pkg::CTR_W'({rc0, 1'b0}) + cgps_pkg::CTR_W'(stride_eff);
      unk_q      <= cost_neg;
      zero_q     <= n_zero;
      full_q     <= n_full;
    end
  end

  // ---- divider ----
  logic                       div_done;
  logic [cgps_pkg::QUO_W-1:0] quo;

  cgps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num_s[VW-1:0]),
    .den_i   (den_eff),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // ---- gradient position and endpoints ----
  logic [cgps_pkg::NQ_W-1:0] n_val, n_ofs, t_val;
  logic                      seg_hi, pastel;
  logic [cgps_pkg::PAL_W-1:0] pal_idx;
  cgps_pkg::pct_t            lo_pct [3];
  cgps_pkg::pct_t            hi_pct [3];

  always_comb begin
    if (zero_q) begin
      n_val = '0;
    end else if (full_q) begin
      n_val = cgps_pkg::ONE_Q;
    end else begin
      n_val = {1'b0, quo};
    end
    pastel  = (pal_q >= cgps_pkg::PAL_PASTEL) && (pal_q <= cgps_pkg::PAL_CYAN);
    pal_idx = pal_q - cgps_pkg::PAL_PASTEL;
    seg_hi  = n_val >= cgps_pkg::HALF_Q;
    n_ofs   = seg_hi ? (n_val - cgps_pkg::HALF_Q) : n_val;
    t_val   = pastel ? n_val : {n_ofs[cgps_pkg::NQ_W-2:0], 1'b0};
    for (int k = 0; k < 3; k++) begin
      if (pastel) begin
        lo_pct[k] = cgps_pkg::PASTEL_TAB[pal_idx][k];
        hi_pct[k] = cgps_pkg::PASTEL_TAB[pal_idx][k+3];
      end else if (seg_hi) begin
        lo_pct[k] = cgps_pkg::SAFETY_TAB[1][k];
        hi_pct[k] = cgps_pkg::SAFETY_TAB[2][k];
      end else begin
        lo_pct[k] = cgps_pkg::SAFETY_TAB[0][k];
        hi_pct[k] = cgps_pkg::SAFETY_TAB[1][k];
      end
    end
  end

  // ---- color lanes ----
  logic [cgps_pkg::CHAN_W-1:0] chan [3];

  for (genvar g = 0; g < 3; g++) begin : g_lane
    cgps_blend u_blend (
      .clk_i  (clk_i),
      .t_i    (t_val),
      .lo_i   (lo_pct[g]),
      .hi_i   (hi_pct[g]),
      .chan_o (chan[g])
    );
  end

  // ---- output register ----
  logic                        out_valid_q, out_valid_d;
  logic [cgps_pkg::CHAN_W-1:0] red_q, green_q, blue_q;
  logic [cgps_pkg::CHAN_W-1:0] red_d, green_d, blue_d;
  logic [cgps_pkg::CTR_W-1:0]  ocol_q, orow_q;
  logic                        ounk_q;

  always_comb begin
    if (!unk_q) begin
      red_d   = chan[0];
      green_d = chan[1];
      blue_d  = chan[2];
    end else if (pal_q == cgps_pkg::PAL_PASTEL) begin
      red_d   = cgps_pkg::GREY_PASTEL_RG;
      green_d = cgps_pkg::GREY_PASTEL_RG;
      blue_d  = cgps_pkg::GREY_PASTEL_B;
    end else begin
      red_d   = cgps_pkg::GREY_DARK;
      green_d = cgps_pkg::GREY_DARK;
      blue_d  = cgps_pkg::GREY_DARK;
    end
    if (cmd_i.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      ocol_q  <= col_half_q;
      orow_q  <= row_half_q;
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      ounk_q  <= unk_q;
    end
  end

  // ---- status ----
  assign status_o.keep     = keep;
  assign status_o.need_div = !cost_neg && !n_zero && !n_full;
  assign status_o.div_done = div_done;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o       = out_valid_q;
  assign center_col_half_o = ocol_q;
  assign center_row_half_o = orow_q;
  assign red_o             = red_q;
  assign green_o           = green_q;
  assign blue_o            = blue_q;
  assign is_unknown_o      = ounk_q;

endmodule

/* rtl/cgps_ctrl.sv */
// Controller: sequences accept, normalization divide, color blend and result load.
// Depends on cgps_pkg.
module cgps_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  cgps_pkg::cgps_status_t status_i,
  output cgps_pkg::cgps_cmd_t    cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DIV   = 2'd1;
  localparam logic [1:0] ST_BLEND = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;
  localparam logic [1:0] BLEND_LAST = 2'(cgps_pkg::BLEND_LAT - 1);

  logic [1:0] state_q, state_d;
  logic [1:0] cnt_q, cnt_d;
  logic       accept;

  always_comb begin
    accept  = in_valid_i && (state_q == ST_IDLE);
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o.accept    = accept;
    cmd_o.div_start = accept && status_i.keep && status_i.need_div;
    cmd_o.load_out  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (accept && status_i.keep) begin
          state_d = status_i.need_div ? ST_DIV : ST_BLEND;
        end
      end
      ST_DIV: begin
        if (status_i.div_done) begin
          state_d = ST_BLEND;
        end
      end
      ST_BLEND: begin
        // wait out the channel pipeline
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == BLEND_LAST) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

/* rtl/cost_grid_pseudocolor_sampler.sv */
// Cost grid pseudocolor sampler: takes grid cells in raster order, keeps every
// stride-th column and row, and emits each kept cell's center in half-cell units
// with an RGB color from the selected gradient palette. A dropped cell is taken
// and discarded. A kept cell skips the divider when no division is needed
// (unknown cells, costs at or below min_cost or at or above max_cost);
// otherwise the normalization divider yields one quotient bit per cycle. The
// three color channels pass through a 3-stage blend pipeline. The result sits in
// an output register, so a new cell is taken while the previous result waits.
// Depends on cgps_pkg, cgps_ctrl and cgps_datapath.
module cost_grid_pseudocolor_sampler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [cgps_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [cgps_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // cell stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [cgps_pkg::S_TDATA_W-1:0]   s_axis_tdata,  // [7:0] cell_cost
  input  logic                             s_axis_tuser,  // [0] frame_start
  // sample stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [13:0] center_col_half, [27:14] center_row_half, [35:28] red,
  // [43:36] green, [51:44] blue, [55:52] zero
  output logic [cgps_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tuser   // [0] is_unknown
);

  cgps_pkg::cgps_cmd_t    cmd;
  cgps_pkg::cgps_status_t status;

  logic [cgps_pkg::CTR_W-1:0]  col_half, row_half;
  logic [cgps_pkg::CHAN_W-1:0] red, green, blue;

  cgps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cgps_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .cell_cost_i       (s_axis_tdata[cgps_pkg::COST_W-1:0]),
    .frame_start_i     (s_axis_tuser),
    .cmd_i             (cmd),
    .status_o          (status),
    .out_ready_i       (m_axis_tready),
    .out_valid_o       (m_axis_tvalid),
    .center_col_half_o (col_half),
    .center_row_half_o (row_half),
    .red_o             (red),
    .green_o           (green),
    .blue_o            (blue),
    .is_unknown_o      (m_axis_tuser)
  );

  // pack result fields, lowest first
  assign m_axis_tdata = {4'h0, blue, green, red, row_half, col_half};

endmodule

/* rtl/cgps_checker.sv */
// Port-level checks for the cost grid pseudocolor sampler, bound to the top level.
// Depends on cgps_pkg.
module cgps_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cgps_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic                            m_axis_tuser
);

  logic [cgps_pkg::CHAN_W-1:0] r, g, b;
  assign r = m_axis_tdata[35:28];
  assign g = m_axis_tdata[43:36];
  assign b = m_axis_tdata[51:44];

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // unknown cells carry one of the two greys
  a_grey: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |->
      (r == cgps_pkg::GREY_DARK && g == cgps_pkg::GREY_DARK && b == cgps_pkg::GREY_DARK) ||
      (r == cgps_pkg::GREY_PASTEL_RG && g == cgps_pkg::GREY_PASTEL_RG &&
       b == cgps_pkg::GREY_PASTEL_B))
    else $error("unknown cell without grey");

  // a result is loaded only after the cell input has closed for processing
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result appeared while input was open");

  // padding bits stay zero
  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[55:52] == 4'h0)
    else $error("padding bits set");

endmodule

bind cost_grid_pseudocolor_sampler cgps_checker u_cgps_checker (.*);
